>>> sv/table_linear_interpolator_defines.svh
// assertion macros used by the interpolator rtl
`ifndef TABLE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define TABLE_LINEAR_INTERPOLATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define TLI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TLI_ASSERT(lbl, prop, msg)
`define TLI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> sv/tli_pkg.sv
package tli_pkg;

  localparam int NUM_TUBES   = 8;
  localparam int NUM_BINS    = 32;
  localparam int TABLE_DEPTH = NUM_TUBES * NUM_BINS;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int BIN_W       = $clog2(NUM_BINS);

  localparam int TUBE_W      = 3;
  localparam int BIN_IN_W    = 5;
  localparam int WL_W        = 16;
  localparam int EFF_W       = 16;
  localparam int PROD_W      = EFF_W + WL_W;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic [WL_W-1:0]  wl;
    logic [EFF_W-1:0] eff;
  } tli_entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tli_div_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAST,
    ST_FIRST,
    ST_CHECK,
    ST_SCAN,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_DONE
  } tli_state_t;

  function automatic logic [ADDR_W-1:0] tli_addr(input logic [TUBE_W-1:0] tube,
                                                 input logic [BIN_IN_W-1:0] bin);
    int full;
    full = int'(tube) * NUM_BINS + int'(bin);
    return ADDR_W'(full);
  endfunction

endpackage

>>> sv/tli_ram.sv
module tli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/tli_div.sv
module tli_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tli_pkg::PROD_W-1:0] dividend,
  input  logic [tli_pkg::WL_W-1:0]   divisor,
  output tli_pkg::tli_div_sts_t      sts,
  output logic [tli_pkg::EFF_W-1:0]  quotient
);

  import tli_pkg::*;

  localparam int CNT_W = $clog2(EFF_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WL_W-1:0]  rem_r, rem_nxt;
  logic [EFF_W-1:0] quo_r, quo_nxt;
  logic [WL_W-1:0]  dsr_r, dsr_nxt;
  logic [WL_W:0]    trial;
  logic             ge;

  // restoring divide, one quotient bit a cycle; quotient bits replace the
  // low dividend bits as they shift out
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    trial    = {rem_r, quo_r[EFF_W-1]};
    ge       = trial >= {1'b0, dsr_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = dividend[PROD_W-1:EFF_W];
      quo_nxt  = dividend[EFF_W-1:0];
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? WL_W'(trial - {1'b0, dsr_r}) : trial[WL_W-1:0];
      quo_nxt = {quo_r[EFF_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(EFF_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

>>> sv/table_linear_interpolator.sv
// channel  dir  beat carries                                   handshake
// in       in   kind, tube, bin, wavelength, efficiency         in_valid / in_stall
// out      out  result_efficiency, found                        out_valid / out_stall
//
// a load beat writes the breakpoint memory directly
// a query ends early on an endpoint match or out of range; otherwise it
// scans the bins (one memory read per cycle), then runs the restoring divider
// reset is synchronous, active low; the breakpoint memory is not cleared
// out_stall holds the result in the output register; a finished query
// waits in ST_DONE only while the output register is full and out_stall is high
module table_linear_interpolator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_kind,
  input  logic [tli_pkg::TUBE_W-1:0]   in_tube,
  input  logic [tli_pkg::BIN_IN_W-1:0] in_bin,
  input  logic [tli_pkg::WL_W-1:0]     in_wavelength,
  input  logic [tli_pkg::EFF_W-1:0]    in_efficiency,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tli_pkg::EFF_W-1:0]    out_result_efficiency,
  output logic                         out_found
);

  import tli_pkg::*;

`include "table_linear_interpolator_defines.svh"

  tli_state_t       state_r, state_nxt;
  logic [WL_W-1:0]  w_r, w_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [BIN_W-1:0] idx_r, idx_nxt;
  logic [WL_W-1:0]  last_w_r, last_w_nxt;
  logic [EFF_W-1:0] last_e_r, last_e_nxt;
  logic [WL_W-1:0]  prev_w_r, prev_w_nxt;
  logic [EFF_W-1:0] prev_e_r, prev_e_nxt;
  logic [EFF_W-1:0] hq1_r, hq1_nxt;
  logic [EFF_W-1:0] diff_r, diff_nxt;
  logic             neg_r, neg_nxt;
  logic [WL_W-1:0]  dw_r, dw_nxt;
  logic [WL_W-1:0]  span_r, span_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [EFF_W-1:0] res_r, res_nxt;
  logic             found_r, found_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [EFF_W-1:0] out_eff_r, out_eff_nxt;
  logic             out_found_r, out_found_nxt;

  logic              in_beat;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  tli_entry_t        wr_entry;
  tli_entry_t        rd_entry;
  logic [$bits(tli_entry_t)-1:0] ram_rdata;
  logic              div_start;
  tli_div_sts_t      div_sts;
  logic [EFF_W-1:0]  div_q;

  assign in_stall  = state_r != ST_IDLE;
  assign in_beat   = in_valid && !in_stall;
  assign ram_we    = in_beat && in_kind == KIND_LOAD && int'(in_tube) < NUM_TUBES &&
                     int'(in_bin) < NUM_BINS;
  assign ram_waddr = tli_addr(in_tube, in_bin);
  assign wr_entry.wl  = in_wavelength;
  assign wr_entry.eff = in_efficiency;
  assign rd_entry  = tli_entry_t'(ram_rdata);
  assign div_start = state_r == ST_START;

  tli_ram #(
    .WIDTH($bits(tli_entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wr_entry),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  tli_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(prod_r),
    .divisor (span_r),
    .sts     (div_sts),
    .quotient(div_q)
  );

  always_comb begin
    state_nxt     = state_r;
    w_nxt         = w_r;
    base_nxt      = base_r;
    idx_nxt       = idx_r;
    last_w_nxt    = last_w_r;
    last_e_nxt    = last_e_r;
    prev_w_nxt    = prev_w_r;
    prev_e_nxt    = prev_e_r;
    hq1_nxt       = hq1_r;
    diff_nxt      = diff_r;
    neg_nxt       = neg_r;
    dw_nxt        = dw_r;
    span_nxt      = span_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    found_nxt     = found_r;
    out_eff_nxt   = out_eff_r;
    out_found_nxt = out_found_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_raddr     = base_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_beat && in_kind == KIND_QUERY) begin
          w_nxt     = in_wavelength;
          base_nxt  = tli_addr(in_tube, '0);
          res_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = (int'(in_tube) < NUM_TUBES) ? ST_LAST : ST_DONE;
        end
      end
      ST_LAST: begin
        ram_raddr = base_r + ADDR_W'(NUM_BINS - 1);
        state_nxt = ST_FIRST;
      end
      ST_FIRST: begin
        ram_raddr  = base_r;
        last_w_nxt = rd_entry.wl;
        last_e_nxt = rd_entry.eff;
        state_nxt  = ST_CHECK;
      end
      ST_CHECK: begin
        // entry 0 is on the read port; start the scan at bin 1
        ram_raddr  = base_r + ADDR_W'(1);
        idx_nxt    = BIN_W'(1);
        prev_w_nxt = rd_entry.wl;
        prev_e_nxt = rd_entry.eff;
        if (w_r == last_w_r) begin
          res_nxt   = last_e_r;
          found_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else if (w_r == rd_entry.wl) begin
          res_nxt   = rd_entry.eff;
          found_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else if (w_r >= rd_entry.wl && w_r < last_w_r) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCAN: begin
        ram_raddr = base_r + ADDR_W'(idx_r) + ADDR_W'(1);
        if (w_r >= prev_w_r && w_r < rd_entry.wl) begin
          hq1_nxt   = prev_e_r;
          neg_nxt   = rd_entry.eff < prev_e_r;
          diff_nxt  = (rd_entry.eff < prev_e_r) ? prev_e_r - rd_entry.eff
                                                : rd_entry.eff - prev_e_r;
          dw_nxt    = w_r - prev_w_r;
          span_nxt  = rd_entry.wl - prev_w_r;
          state_nxt = ST_MUL;
        end else if (idx_r == BIN_W'(NUM_BINS - 1)) begin
          // table not ascending: no bin holds the wavelength
          state_nxt = ST_DONE;
        end else begin
          prev_w_nxt = rd_entry.wl;
          prev_e_nxt = rd_entry.eff;
          idx_nxt    = idx_r + BIN_W'(1);
        end
      end
      ST_MUL: begin
        prod_nxt  = PROD_W'(diff_r) * PROD_W'(dw_r);
        state_nxt = ST_START;
      end
      ST_START: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_sts.done) begin
          res_nxt   = neg_r ? hq1_r - div_q : hq1_r + div_q;
          found_nxt = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_eff_nxt   = res_r;
          out_found_nxt = found_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    w_r         <= w_nxt;
    base_r      <= base_nxt;
    idx_r       <= idx_nxt;
    last_w_r    <= last_w_nxt;
    last_e_r    <= last_e_nxt;
    prev_w_r    <= prev_w_nxt;
    prev_e_r    <= prev_e_nxt;
    hq1_r       <= hq1_nxt;
    diff_r      <= diff_nxt;
    neg_r       <= neg_nxt;
    dw_r        <= dw_nxt;
    span_r      <= span_nxt;
    prod_r      <= prod_nxt;
    res_r       <= res_nxt;
    found_r     <= found_nxt;
    out_eff_r   <= out_eff_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_result_efficiency = out_eff_r;
  assign out_found             = out_found_r;

  `TLI_ASSERT_NEXT(a_load_stays_idle, in_beat && in_kind == KIND_LOAD, state_r == ST_IDLE,
                   "load beat left idle")
  `TLI_ASSERT(a_rise_from_done, $rose(out_valid_r) |-> $past(state_r == ST_DONE),
              "result without query")
  `TLI_ASSERT(a_div_done_in_div, div_sts.done |-> state_r == ST_DIV, "divider done out of step")
  `TLI_ASSERT(a_miss_is_zero, out_valid_r && !out_found_r |-> out_eff_r == '0,
              "miss with nonzero result")

endmodule
